// File: rtl/core/alu8_pkg.sv
package alu8_pkg;

  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_AND   = 5'd4,
    OP_XOR   = 5'd5,
    OP_OR    = 5'd6,
    OP_INC   = 5'd7,
    OP_DEC   = 5'd8,
    OP_DAA   = 5'd9,
    OP_RLC   = 5'd10,
    OP_RRC   = 5'd11,
    OP_RL    = 5'd12,
    OP_RR    = 5'd13,
    OP_SLA   = 5'd14,
    OP_SRA   = 5'd15,
    OP_SWAP  = 5'd16,
    OP_SRL   = 5'd17,
    OP_BIT   = 5'd18,
    OP_ADD16 = 5'd19,
    OP_ADDSP = 5'd20
  } alu_op_e;

  localparam int unsigned FlagZ = 7;
  localparam int unsigned FlagN = 6;
  localparam int unsigned FlagH = 5;
  localparam int unsigned FlagC = 4;

  localparam logic [7:0] DaaLowAdj  = 8'h06;
  localparam logic [7:0] DaaHighAdj = 8'h60;
  localparam logic [7:0] DaaMaxBcd  = 8'h99;
  localparam logic [3:0] DaaMaxDig  = 4'h9;

  typedef struct packed {
    logic [4:0]  operation;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic        carry_in;
    logic [7:0]  flag_byte;
    logic [2:0]  bit_index;
  } alu8_in_t;

  typedef struct packed {
    logic [15:0] result_value;
    logic [7:0]  flags_out;
  } alu8_out_t;

  function automatic logic [7:0] mk_flags(input logic z, input logic n,
                                          input logic h, input logic c);
    mk_flags = {z, n, h, c, 4'h0};
  endfunction

endpackage

// File: rtl/core/alu8_in_if.sv
interface alu8_in_if;
  logic                valid;
  logic                ready;
  alu8_pkg::alu8_in_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/alu8_out_if.sv
interface alu8_out_if;
  logic                valid;
  logic                ready;
  alu8_pkg::alu8_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/eight_bit_alu_with_flags.sv
// Eight-bit ALU with Z/N/H/C flags: each request beat carries one operation, its operands,
// the carry input and the current flag byte, and yields exactly one response beat with the
// result and the new flag byte (low nibble always zero). The block takes one beat per clock
// cycle unless stalled, and returns its response through an input register and a result
// register with all arithmetic between them; back-pressure on the response side stalls
// the two registers in turn and holds the request side only when both are full.
module eight_bit_alu_with_flags (
  input logic        clk_i,
  input logic        rst_ni,
  alu8_in_if.sink    req_i,
  alu8_out_if.source rsp_o
);

  logic                s1_valid_q;
  alu8_pkg::alu8_in_t  s1_data_q;
  logic                s2_valid_q;
  alu8_pkg::alu8_out_t s2_data_q;
  alu8_pkg::alu8_out_t exec_res;
  logic                s2_ready;
  logic                s1_fire;
  logic                in_fire;

  assign s2_ready    = !s2_valid_q || rsp_o.ready;
  assign s1_fire     = s1_valid_q && s2_ready;
  assign req_i.ready = !s1_valid_q || s2_ready;
  assign in_fire     = req_i.valid && req_i.ready;

  alu8_exec u_exec (
    .op_i  (s1_data_q),
    .res_o (exec_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) s1_valid_q <= req_i.valid;
      if (s2_ready) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) s1_data_q <= req_i.payload;
    if (s1_fire) s2_data_q <= exec_res;
  end

  assign rsp_o.valid   = s2_valid_q;
  assign rsp_o.payload = s2_data_q;

  a_in_to_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted request beat did not reach the input register");

  a_s1_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> rsp_o.valid)
    else $error("executed beat did not reach the result register");

  a_no_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_ready) |=> s1_valid_q && $stable(s1_data_q))
    else $error("stalled beat in the input register was lost or overwritten");

endmodule

// File: rtl/core/alu8_exec.sv
module alu8_exec (
  input  alu8_pkg::alu8_in_t  op_i,
  output alu8_pkg::alu8_out_t res_o
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic        cin_use;
  logic [8:0]  add_sum;
  logic [4:0]  add_half;
  logic [8:0]  sub_diff;
  logic [4:0]  sub_half;
  logic        fn;
  logic        fh;
  logic        fc;
  logic [7:0]  daa_adj;
  logic        daa_c;
  logic [7:0]  daa_val;
  logic [16:0] sum16;
  logic [12:0] half16;
  logic [15:0] sp_sum;
  logic [4:0]  sp_half;
  logic [8:0]  sp_low;
  logic [7:0]  v8;

  assign a       = op_i.operand_a[7:0];
  assign b       = op_i.operand_b[7:0];
  assign cin_use = op_i.carry_in &
                   ((op_i.operation == alu8_pkg::OP_ADC) ||
                    (op_i.operation == alu8_pkg::OP_SBC));

  assign add_sum  = {1'b0, a} + {1'b0, b} + {8'h00, cin_use};
  assign add_half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cin_use};
  assign sub_diff = {1'b0, a} - {1'b0, b} - {8'h00, cin_use};
  assign sub_half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, cin_use};

  assign fn = op_i.flag_byte[alu8_pkg::FlagN];
  assign fh = op_i.flag_byte[alu8_pkg::FlagH];
  assign fc = op_i.flag_byte[alu8_pkg::FlagC];

  // After a subtraction only the recorded half and full borrows steer the fix-up.
  always_comb begin
    daa_adj = 8'h00;
    daa_c   = fc;
    if (fn) begin
      if (fh) daa_adj = daa_adj | alu8_pkg::DaaLowAdj;
      if (fc) daa_adj = daa_adj | alu8_pkg::DaaHighAdj;
      daa_val = a - daa_adj;
    end else begin
      if (fh || (a[3:0] > alu8_pkg::DaaMaxDig)) daa_adj = daa_adj | alu8_pkg::DaaLowAdj;
      if (fc || (a > alu8_pkg::DaaMaxBcd)) begin
        daa_adj = daa_adj | alu8_pkg::DaaHighAdj;
        daa_c   = 1'b1;
      end
      daa_val = a + daa_adj;
    end
  end

  assign sum16   = {1'b0, op_i.operand_a} + {1'b0, op_i.operand_b};
  assign half16  = {1'b0, op_i.operand_a[11:0]} + {1'b0, op_i.operand_b[11:0]};
  assign sp_sum  = op_i.operand_a + {{8{b[7]}}, b};
  assign sp_half = {1'b0, op_i.operand_a[3:0]} + {1'b0, b[3:0]};
  assign sp_low  = {1'b0, op_i.operand_a[7:0]} + {1'b0, b};

  always_comb begin
    v8                 = 8'h00;
    res_o.result_value = 16'h0000;
    res_o.flags_out    = {op_i.flag_byte[7:4], 4'h0};
    unique case (op_i.operation) inside
      alu8_pkg::OP_ADD, alu8_pkg::OP_ADC: begin
        v8              = add_sum[7:0];
        res_o.flags_out = alu8_pkg::mk_flags(v8 == 8'h00, 1'b0, add_half[4], add_sum[8]);
      end
      alu8_pkg::OP_SUB, alu8_pkg::OP_SBC: begin
        v8              = sub_diff[7:0];
        res_o.flags_out = alu8_pkg::mk_flags(v8 == 8'h00, 1'b1, sub_half[4], sub_diff[8]);
      end
      alu8_pkg::OP_AND: begin
        v8              = a & b;
        res_o.flags_out = alu8_pkg::mk_flags(v8 == 8'h00, 1'b0, 1'b1, 1'b0);
      end
      alu8_pkg::OP_XOR: begin
        v8              = a ^ b;
        res_o.flags_out = alu8_pkg::mk_flags(v8 == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      alu8_pkg::OP_OR: begin
        v8              = a | b;
        res_o.flags_out = alu8_pkg::mk_flags(v8 == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      alu8_pkg::OP_INC: begin
        v8              = a + 8'h01;
        res_o.flags_out = alu8_pkg::mk_flags(v8 == 8'h00, 1'b0, a[3:0] == 4'hF, fc);
      end
      alu8_pkg::OP_DEC: begin
        v8              = a - 8'h01;
        res_o.flags_out = alu8_pkg::mk_flags(v8 == 8'h00, 1'b1, a[3:0] == 4'h0, fc);
      end
      alu8_pkg::OP_DAA: begin
        v8              = daa_val;
        res_o.flags_out = alu8_pkg::mk_flags(v8 == 8'h00, fn, 1'b0, daa_c);
      end
      alu8_pkg::OP_RLC: begin
        v8              = {a[6:0], a[7]};
        res_o.flags_out = alu8_pkg::mk_flags(v8 == 8'h00, 1'b0, 1'b0, a[7]);
      end
      alu8_pkg::OP_RRC: begin
        v8              = {a[0], a[7:1]};
        res_o.flags_out = alu8_pkg::mk_flags(v8 == 8'h00, 1'b0, 1'b0, a[0]);
      end
      alu8_pkg::OP_RL: begin
        v8              = {a[6:0], op_i.carry_in};
        res_o.flags_out = alu8_pkg::mk_flags(v8 == 8'h00, 1'b0, 1'b0, a[7]);
      end
      alu8_pkg::OP_RR: begin
        v8              = {op_i.carry_in, a[7:1]};
        res_o.flags_out = alu8_pkg::mk_flags(v8 == 8'h00, 1'b0, 1'b0, a[0]);
      end
      alu8_pkg::OP_SLA: begin
        v8              = {a[6:0], 1'b0};
        res_o.flags_out = alu8_pkg::mk_flags(v8 == 8'h00, 1'b0, 1'b0, a[7]);
      end
      alu8_pkg::OP_SRA: begin
        v8              = {a[7], a[7:1]};
        res_o.flags_out = alu8_pkg::mk_flags(v8 == 8'h00, 1'b0, 1'b0, a[0]);
      end
      alu8_pkg::OP_SWAP: begin
        v8              = {a[3:0], a[7:4]};
        res_o.flags_out = alu8_pkg::mk_flags(v8 == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      alu8_pkg::OP_SRL: begin
        v8              = {1'b0, a[7:1]};
        res_o.flags_out = alu8_pkg::mk_flags(v8 == 8'h00, 1'b0, 1'b0, a[0]);
      end
      alu8_pkg::OP_BIT: begin
        res_o.flags_out = alu8_pkg::mk_flags(!a[op_i.bit_index], 1'b0, 1'b1, fc);
      end
      alu8_pkg::OP_ADD16: begin
        res_o.result_value = sum16[15:0];
        res_o.flags_out    = alu8_pkg::mk_flags(op_i.flag_byte[alu8_pkg::FlagZ], 1'b0,
                                                half16[12], sum16[16]);
      end
      alu8_pkg::OP_ADDSP: begin
        res_o.result_value = sp_sum;
        res_o.flags_out    = alu8_pkg::mk_flags(1'b0, 1'b0, sp_half[4], sp_low[8]);
      end
      default: begin
        res_o.flags_out = {op_i.flag_byte[7:4], 4'h0};
      end
    endcase
    if ((op_i.operation != alu8_pkg::OP_ADD16) && (op_i.operation != alu8_pkg::OP_ADDSP)) begin
      res_o.result_value = {8'h00, v8};
    end
  end

endmodule
